// File: rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// shared constants, types and codes of the cell bitmap allocator
// ----------------------------------------------------------------------------
package cba_pkg;

   localparam int NUM_CELLS  = 4096;
   localparam int CELL_BYTES = 64;
   localparam int CELL_SHIFT = $clog2(CELL_BYTES);
   localparam int CELL_W     = $clog2(NUM_CELLS);
   localparam int CNT_W      = CELL_W + 1;

   // cells packed into one memory row
   localparam int WORD_CELLS = 16;
   localparam int WORD_SHIFT = $clog2(WORD_CELLS);
   localparam int NUM_ROWS   = NUM_CELLS / WORD_CELLS;
   localparam int ROW_W      = $clog2(NUM_ROWS);

   // request field widths
   localparam int CMD_W  = 3;
   localparam int BASE_W = 18;
   localparam int SIZE_W = 19;
   localparam int NEED_W = SIZE_W + 1 - CELL_SHIFT;
   localparam int SUM_W  = NEED_W + 1;

   // per-cell marks
   localparam logic [1:0] MARK_NONE = 2'b00;
   localparam logic [1:0] MARK_USED = 2'b01;
   localparam logic [1:0] MARK_RESV = 2'b10;

   typedef logic [WORD_CELLS-1:0][1:0] cell_word_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_MARK_RESV = 3'd0,
      CMD_MARK_USED = 3'd1,
      CMD_MARK_FREE = 3'd2,
      CMD_ALLOC     = 3'd3,
      CMD_FIND      = 3'd4,
      CMD_LAST      = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_MARK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              free_hit;
      logic [CELL_W-1:0] free_start;
      logic [CNT_W-1:0]  run_out;
      logic              last_hit;
      logic [CELL_W-1:0] last_cell;
   } scan_res_type;

endpackage

// File: rtl/cba_word_scan.sv
// ----------------------------------------------------------------------------
// cba_word_scan
// first-fit and highest-marked search over one row of the cell map
// ----------------------------------------------------------------------------
module cba_word_scan import cba_pkg::*; (
   input  logic [ROW_W-1:0] row,
   input  cell_word_type    word,
   input  logic [CNT_W-1:0] lim,
   input  logic [CNT_W-1:0] need,
   input  logic [CNT_W-1:0] run_prev,
   output scan_res_type     res
);

   logic [CNT_W-1:0]      cidx [WORD_CELLS];
   logic [WORD_CELLS-1:0] free;
   logic [WORD_CELLS-1:0] marked;
   logic [WORD_CELLS-1:0] hit;
   logic                  has_zero;
   logic [WORD_SHIFT-1:0] lastz;
   logic [CNT_W-1:0]      run_j;
   logic [CNT_W-1:0]      run_last;
   logic [WORD_SHIFT-1:0] fpos;
   logic [WORD_SHIFT-1:0] lpos;

   always_comb begin
      for (int j = 0; j < WORD_CELLS; j++) begin
         cidx[j]   = {1'b0, row, WORD_SHIFT'(j)};
         free[j]   = (cidx[j] < lim) && (word[j] == MARK_NONE);
         marked[j] = (cidx[j] < lim) && (word[j] != MARK_NONE) && (cidx[j] != '0);
      end

      // free run ending at each cell, carried in from earlier rows when unbroken
      run_last = '0;
      run_j    = '0;
      has_zero = 1'b0;
      lastz    = '0;
      for (int j = 0; j < WORD_CELLS; j++) begin
         has_zero = 1'b0;
         lastz    = '0;
         for (int k = 0; k < WORD_CELLS; k++) begin
            if ((k <= j) && !free[k]) begin
               has_zero = 1'b1;
               lastz    = WORD_SHIFT'(k);
            end
         end
         if (has_zero) begin
            run_j = CNT_W'(WORD_SHIFT'(j) - lastz);
         end else begin
            run_j = run_prev + CNT_W'(j + 1);
         end
         hit[j] = free[j] && ((need == '0) || (run_j >= need));
         if (j == WORD_CELLS - 1) begin
            run_last = run_j;
         end
      end

      // lowest hit, highest marked cell
      fpos = '0;
      for (int j = WORD_CELLS - 1; j >= 0; j--) begin
         if (hit[j]) begin
            fpos = WORD_SHIFT'(j);
         end
      end
      lpos = '0;
      for (int j = 0; j < WORD_CELLS; j++) begin
         if (marked[j]) begin
            lpos = WORD_SHIFT'(j);
         end
      end
   end

   always_comb begin
      res.free_hit = |hit;
      if (need == '0) begin
         res.free_start = cidx[fpos][CELL_W-1:0];
      end else begin
         res.free_start = CELL_W'(cidx[fpos] + CNT_W'(1) - need);
      end
      res.run_out   = run_last;
      res.last_hit  = |marked;
      res.last_cell = cidx[lpos][CELL_W-1:0];
   end

endmodule

// File: rtl/cell_bitmap_allocator.sv
// walk: each map row is read in turn, one row of 16 cells per cycle through the single
// read port of the map memory; trivial requests skip the walk
// find/alloc: up to 256 rows scanned; alloc adds a write-back walk over the run's rows
// throughput: one request at a time, next request taken as soon as the result is queued
// reset: synchronous; every row valid bit cleared at once so the map reads as all free,
// no clearing pass; cells_in_use returns to 4096
// ----------------------------------------------------------------------------
// cell_bitmap_allocator
// first-fit cell allocator over a two-mark cell map held in a row memory
// ----------------------------------------------------------------------------
module cell_bitmap_allocator import cba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [BASE_W-1:0] req_base_byte,
   input  logic [SIZE_W-1:0] req_size_bytes,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CELL_W-1:0] rsp_cell_index,
   output logic              rsp_ok,
   // cells_in_use register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CNT_W-1:0]  csr_cells_in_use
);

   // control state
   state_type         state_ff, state_in;
   logic              more_ff, more_in;   // reads still to issue
   logic              dval_ff, dval_in;   // read data returns this cycle
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  cells_in_use_ff;

   // walk and result payload
   cmd_type           op_ff, op_in;
   logic [ROW_W-1:0]  ptr_ff, ptr_in;     // next row to read
   logic [ROW_W-1:0]  stop_ff, stop_in;   // final row of the walk
   logic [ROW_W-1:0]  daddr_ff;           // row whose data is returning
   logic [CNT_W-1:0]  need_ff, need_in;
   logic [CNT_W-1:0]  run_cnt_ff, run_cnt_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CELL_W-1:0] res_cell_ff, res_cell_in;
   logic              res_ok_ff, res_ok_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic              rsp_ok_ff, rsp_ok_in;

   // map memory, one row of cells per word, with a valid bit per row
   cell_word_type     cell_mem [NUM_ROWS];
   logic [NUM_ROWS-1:0] row_valid_ff;
   cell_word_type     mem_q_ff;
   logic              rowv_q_ff;
   cell_word_type     rd_word;
   cell_word_type     wr_word;
   logic              rd_en;
   logic              mem_we;

   // request decode
   logic              accept;
   cmd_type           req_cmd;
   logic [NEED_W-1:0] req_need;
   logic [CNT_W-1:0]  req_lo;
   logic [SUM_W-1:0]  req_hi_raw;
   logic              req_clip;
   logic [CNT_W-1:0]  req_hi;
   logic [CNT_W-1:0]  req_hi_m1;
   logic [CNT_W-1:0]  lim;
   logic [CNT_W-1:0]  lim_m1;
   logic [CNT_W-1:0]  alloc_lo;
   logic [CNT_W-1:0]  alloc_hi_m1;
   logic [CNT_W-1:0]  cell_j;

   scan_res_type      scan_res;

   assign req_ready      = (state_ff == ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_cell_ff;
   assign rsp_ok         = rsp_ok_ff;

   assign accept  = req_valid && req_ready;
   assign req_cmd = cmd_type'(req_command);

   // searches never go past the map
   assign lim    = (cells_in_use_ff > CNT_W'(NUM_CELLS)) ? CNT_W'(NUM_CELLS) : cells_in_use_ff;
   assign lim_m1 = lim - CNT_W'(1);

   // byte range to cells: start truncated, length rounded up
   assign req_need   = NEED_W'(({1'b0, req_size_bytes} + (SIZE_W+1)'(CELL_BYTES - 1))
                               >> CELL_SHIFT);
   assign req_lo     = CNT_W'(req_base_byte >> CELL_SHIFT);
   assign req_hi_raw = SUM_W'(req_lo) + SUM_W'(req_need);
   assign req_clip   = (req_hi_raw > SUM_W'(NUM_CELLS));
   assign req_hi     = req_clip ? CNT_W'(NUM_CELLS) : req_hi_raw[CNT_W-1:0];
   assign req_hi_m1  = req_hi - CNT_W'(1);

   // run found by the scan, for the alloc write-back
   assign alloc_lo    = {1'b0, scan_res.free_start};
   assign alloc_hi_m1 = alloc_lo + need_ff - CNT_W'(1);

   // map data as the logic sees it: unwritten rows are clear
   assign rd_word = rowv_q_ff ? mem_q_ff : '0;

   cba_word_scan u_scan (
      .row      (daddr_ff),
      .word     (rd_word),
      .lim      (lim),
      .need     (need_ff),
      .run_prev (run_cnt_ff),
      .res      (scan_res)
   );

   // read-modify-write of one row for the mark commands
   always_comb begin
      wr_word = rd_word;
      cell_j  = '0;
      for (int j = 0; j < WORD_CELLS; j++) begin
         cell_j = {1'b0, daddr_ff, WORD_SHIFT'(j)};
         if ((cell_j >= lo_ff) && (cell_j < hi_ff)) begin
            unique case (op_ff)
               CMD_MARK_RESV: wr_word[j] = MARK_USED | MARK_RESV;
               CMD_MARK_USED: wr_word[j] = rd_word[j] | MARK_USED;
               CMD_MARK_FREE: begin
                  // reserved cells survive a free
                  if ((rd_word[j] & MARK_RESV) == MARK_NONE) begin
                     wr_word[j] = MARK_NONE;
                  end
               end
               default: wr_word[j] = rd_word[j];
            endcase
         end
      end
   end

   // sequencer: decode, walk the rows, queue the result
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ptr_in       = ptr_ff;
      stop_in      = stop_ff;
      more_in      = more_ff;
      dval_in      = 1'b0;
      need_in      = need_ff;
      run_cnt_in   = run_cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_cell_in  = res_cell_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cell_in  = rsp_cell_ff;
      rsp_ok_in    = rsp_ok_ff;
      rd_en        = 1'b0;
      mem_we       = 1'b0;

      // row walk shared by scan, last and mark: one read per cycle
      if ((state_ff == ST_SCAN) || (state_ff == ST_LAST) || (state_ff == ST_MARK)) begin
         rd_en   = more_ff;
         dval_in = more_ff;
         if (more_ff) begin
            if (ptr_ff == stop_ff) begin
               more_in = 1'b0;
            end else if (state_ff == ST_LAST) begin
               ptr_in = ptr_ff - ROW_W'(1);
            end else begin
               ptr_in = ptr_ff + ROW_W'(1);
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            more_in = 1'b0;
            if (accept) begin
               op_in = req_cmd;
               unique case (req_cmd)
                  CMD_MARK_RESV, CMD_MARK_USED, CMD_MARK_FREE: begin
                     res_cell_in = '0;
                     res_ok_in   = !req_clip;
                     lo_in       = req_lo;
                     hi_in       = req_hi;
                     if (req_need == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_MARK;
                        ptr_in   = req_lo[CELL_W-1:WORD_SHIFT];
                        stop_in  = req_hi_m1[CELL_W-1:WORD_SHIFT];
                        more_in  = 1'b1;
                     end
                  end
                  CMD_ALLOC, CMD_FIND: begin
                     res_cell_in = '0;
                     res_ok_in   = 1'b0;
                     need_in     = CNT_W'(req_need);
                     run_cnt_in  = '0;
                     // a run longer than the search window can never fit
                     if ((lim == '0) || (req_need > NEED_W'(lim))) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                        ptr_in   = '0;
                        stop_in  = lim_m1[CELL_W-1:WORD_SHIFT];
                        more_in  = 1'b1;
                     end
                  end
                  CMD_LAST: begin
                     res_cell_in = '0;
                     res_ok_in   = 1'b1;
                     // cell 0 is never reported
                     if (lim <= CNT_W'(1)) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_LAST;
                        ptr_in   = lim_m1[CELL_W-1:WORD_SHIFT];
                        stop_in  = '0;
                        more_in  = 1'b1;
                     end
                  end
                  default: begin
                     res_cell_in = '0;
                     res_ok_in   = 1'b0;
                     state_in    = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (dval_ff) begin
               if (scan_res.free_hit) begin
                  res_cell_in = scan_res.free_start;
                  res_ok_in   = 1'b1;
                  dval_in     = 1'b0;
                  if ((op_ff == CMD_ALLOC) && (need_ff != '0)) begin
                     // mark the run used; the row read in flight is dropped
                     state_in = ST_MARK;
                     op_in    = CMD_MARK_USED;
                     lo_in    = alloc_lo;
                     hi_in    = alloc_hi_m1 + CNT_W'(1);
                     ptr_in   = scan_res.free_start[CELL_W-1:WORD_SHIFT];
                     stop_in  = alloc_hi_m1[CELL_W-1:WORD_SHIFT];
                     more_in  = 1'b1;
                  end else begin
                     state_in = ST_DONE;
                     more_in  = 1'b0;
                  end
               end else begin
                  run_cnt_in = scan_res.run_out;
                  if (daddr_ff == stop_ff) begin
                     state_in = ST_DONE;
                     more_in  = 1'b0;
                     dval_in  = 1'b0;
                  end
               end
            end
         end

         ST_LAST: begin
            if (dval_ff) begin
               if (scan_res.last_hit) begin
                  res_cell_in = scan_res.last_cell;
                  state_in    = ST_DONE;
                  more_in     = 1'b0;
                  dval_in     = 1'b0;
               end else if (daddr_ff == stop_ff) begin
                  state_in = ST_DONE;
                  more_in  = 1'b0;
                  dval_in  = 1'b0;
               end
            end
         end

         ST_MARK: begin
            if (dval_ff) begin
               mem_we = 1'b1;
               if (daddr_ff == stop_ff) begin
                  state_in = ST_DONE;
                  more_in  = 1'b0;
                  dval_in  = 1'b0;
               end
            end
         end

         ST_DONE: begin
            // result register frees up as the previous result is taken
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = res_cell_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         more_ff         <= 1'b0;
         dval_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cells_in_use_ff <= CNT_W'(NUM_CELLS);
      end else begin
         state_ff     <= state_in;
         more_ff      <= more_in;
         dval_ff      <= dval_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cells_in_use_ff <= csr_cells_in_use;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ptr_ff      <= ptr_in;
      stop_ff     <= stop_in;
      daddr_ff    <= ptr_ff;
      need_ff     <= need_in;
      run_cnt_ff  <= run_cnt_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_cell_ff <= res_cell_in;
      res_ok_ff   <= res_ok_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   // map memory: write-back port and registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[daddr_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff  <= cell_mem[ptr_ff];
         rowv_q_ff <= row_valid_ff[ptr_ff];
      end
   end

   // row valid bits: a row reads as clear until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (mem_we) begin
         row_valid_ff[daddr_ff] <= 1'b1;
      end
   end

`ifndef SYNTH
   // write-back only from a mark walk, never onto the row being read
   a_we_in_mark: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_MARK) && dval_ff && (!rd_en || (ptr_ff != daddr_ff)))
      else $error("map write outside a mark walk or onto the row being read");

   // an open run never reaches its target without a hit
   a_run_below_need: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (need_ff != '0)) |-> (run_cnt_ff < need_ff))
      else $error("free run counter reached the needed length");

   // a finished request always lands in the result register
   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished request not queued as a result");

   // failures always report cell 0; marks do as well, but only failures are checked here
   a_fail_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_cell_ff == '0))
      else $error("failed request reports a nonzero cell");
`endif

endmodule
